@@ hw/rtl/kre_pkg.sv @@
// shared types, constants and register codes for the kalman rate estimator
`timescale 1ns / 1ps

package kre_pkg;

  // fixed point default: fraction bits of P, Q, R and K
  localparam int FRAC_BITS_DEFAULT = 30;

  // request and result payloads
  typedef struct packed {
    logic        command;
    logic [17:0] bytes;
    logic [23:0] elapsed_ticks;
  } req_t;

  typedef struct packed {
    logic [31:0] average_rate;
    logic [30:0] gain;
  } res_t;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // register map, index is paddr[3:2]
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [1:0] REG_TICKS_PER_SECOND  = 2'd2;

  localparam logic [30:0] PROCESS_NOISE_RESET     = 31'd1074;
  localparam logic [30:0] MEASUREMENT_NOISE_RESET = 31'd10737418;
  localparam logic [29:0] TICKS_PER_SECOND_RESET  = 30'd1000;
  localparam logic [31:0] ESTIMATE_RESET          = 32'd1000000;

  // serial divider geometry
  localparam int DVD_W      = 65;
  localparam int DVS_W      = 33;
  localparam int DIV_STEP_W = 7;
  localparam logic [DIV_STEP_W-1:0] RATE_DIV_STEPS = 7'd65;

  // unit control and status
  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ hw/rtl/kre_mul.sv @@
// bit-serial shift-add multiplier, 32-bit multiplicand by B_W-bit multiplier
`timescale 1ns / 1ps

module kre_mul import kre_pkg::*; #(
  parameter int B_W = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [31:0]       a,
  input  logic [B_W-1:0]    b,
  output unit_stat_t        stat,
  output logic [B_W+31:0]   product
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [31:0]      a_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [32:0]      sum;

  // one multiplier bit per cycle, lsb first, accumulator shifts right
  always_comb begin
    sum = {1'b0, product[B_W+31:B_W]} + (product[0] ? {1'b0, a_q} : 33'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q     <= a;
      product <= {32'd0, b};
    end else if (busy) begin
      product <= {sum, product[B_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ hw/rtl/kre_div.sv @@
// restoring bit-serial divider with sticky quotient overflow
`timescale 1ns / 1ps

module kre_div import kre_pkg::*; #(
  parameter int QUOT_W = 33
) (
  input  logic              clk,
  input  logic              rst,
  input  div_ctl_t          ctl,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output unit_stat_t        stat,
  output logic [QUOT_W-1:0] quotient,
  output logic              overflow
);

  logic [DVS_W-1:0]      rem;
  logic [DVS_W-1:0]      dvs;
  logic [DVD_W-1:0]      dvd;
  logic [DIV_STEP_W-1:0] cnt;
  logic                  busy;
  logic                  done;
  logic [DVS_W:0]        rem_sh;
  logic                  fits;
  logic [DVS_W-1:0]      rem_next;

  // one quotient bit per cycle, dividend bits enter msb first
  always_comb begin
    rem_sh   = {rem, dvd[DVD_W-1]};
    fits     = rem_sh >= {1'b0, dvs};
    rem_next = fits ? DVS_W'(rem_sh - {1'b0, dvs}) : DVS_W'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem      <= '0;
      dvs      <= divisor;
      dvd      <= dividend;
      quotient <= '0;
      overflow <= 1'b0;
    end else if (busy) begin
      rem      <= rem_next;
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      quotient <= {quotient[QUOT_W-2:0], fits};
      overflow <= overflow | quotient[QUOT_W-1];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ hw/rtl/kalman_rate_estimator.sv @@
// link bit-rate estimator: byte counter, rate measurement and scalar kalman step
`timescale 1ns / 1ps
// adds: an add request is taken while idle and the block stays ready for the next request
// updates: an update request runs on one serial multiplier doing three products and
//   one serial divider doing the rate and gain divisions, one bit a cycle
// throughput: one update at a time; adds and updates are taken while a result waits
// reset: synchronous, restores estimate, covariance, byte counter, state and configuration registers

module kalman_rate_estimator import kre_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  // result channel
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // gain width, multiplier width, quotient width
  localparam int KW = FRACTION_BITS + 1;
  localparam int BW = (KW > 30) ? KW : 30;
  localparam int QW = (KW > 33) ? KW : 33;

  localparam logic [KW-1:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [31:0] COV_RESET = 32'(ONE_FIX);
  localparam logic [DIV_STEP_W-1:0] GAIN_DIV_STEPS = DIV_STEP_W'(32 + FRACTION_BITS);

  // sequencer codes
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RATE_MUL = 3'd1;
  localparam logic [2:0] S_RATE_DIV = 3'd2;
  localparam logic [2:0] S_GAIN_DIV = 3'd3;
  localparam logic [2:0] S_EST_MUL  = 3'd4;
  localparam logic [2:0] S_COV_MUL  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state;

  // configuration registers
  logic [30:0] process_noise;
  logic [30:0] measurement_noise;
  logic [29:0] ticks_per_second;

  // filter state
  logic [31:0] estimate;
  logic [31:0] covariance;
  logic [31:0] byte_count;

  // per-update working registers
  logic [23:0]   elapsed_q;
  logic [31:0]   rate_q;
  logic [31:0]   pm_q;
  logic [32:0]   den_q;
  logic [KW-1:0] k_q;
  logic          est_up;

  // shared arithmetic units
  logic             mul_start;
  logic [31:0]      mul_a;
  logic [BW-1:0]    mul_b;
  unit_stat_t       mul_stat;
  logic [BW+31:0]   mul_prod;

  div_ctl_t         div_ctl;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  unit_stat_t       div_stat;
  logic [QW-1:0]    div_quo;
  logic             div_ovf;

  logic        req_take;
  logic        cfg_write;
  logic [32:0] count_sum;
  logic [32:0] pm_sum;
  logic        rate_sat;
  logic [31:0] rate_val;
  logic [KW-1:0] k_val;
  logic        up_val;
  logic [31:0] diff_val;
  logic [31:0] corr;

  assign req_ready = (state == S_IDLE);
  assign req_take  = req_valid && req_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // saturating byte counter and predicted covariance sums
  assign count_sum = {1'b0, byte_count} + {15'd0, req.bytes};
  assign pm_sum    = {1'b0, covariance} + {2'b0, process_noise};

  // measured rate saturates when the quotient runs past 32 bits
  assign rate_sat = div_ovf || (|div_quo[QW-1:32]);
  assign rate_val = rate_sat ? 32'hFFFF_FFFF : div_quo[31:0];

  // zero denominator (only with a zero measurement noise) gives zero gain
  assign k_val    = (den_q == 33'd0) ? '0 : div_quo[KW-1:0];
  assign up_val   = rate_q >= estimate;
  assign diff_val = up_val ? (rate_q - estimate) : (estimate - rate_q);
  assign corr     = mul_prod[FRACTION_BITS+31:FRACTION_BITS];

  // operand selection for the multiplier: rate product, correction, covariance
  always_comb begin
    mul_start = 1'b0;
    mul_a     = pm_q;
    mul_b     = BW'(ONE_FIX - k_q);
    unique case (state)
      S_IDLE: begin
        mul_start = req_take && (req.command == CMD_UPDATE);
        mul_a     = byte_count;
        mul_b     = BW'(ticks_per_second);
      end
      S_GAIN_DIV: begin
        mul_start = div_stat.done;
        mul_a     = diff_val;
        mul_b     = BW'(k_val);
      end
      S_EST_MUL: begin
        mul_start = mul_stat.done;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // operand selection for the divider: bits times ticks over elapsed, then gain
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = GAIN_DIV_STEPS;
    div_dividend  = {pm_q, 33'd0};
    div_divisor   = den_q;
    unique case (state)
      S_RATE_MUL: begin
        div_ctl.start = mul_stat.done;
        div_ctl.steps = RATE_DIV_STEPS;
        div_dividend  = {mul_prod[61:0], 3'b000};
        div_divisor   = {9'd0, elapsed_q};
      end
      S_RATE_DIV: begin
        div_ctl.start = div_stat.done;
      end
      default: begin
        div_ctl.start = 1'b0;
      end
    endcase
  end

  kre_mul #(
    .B_W(BW)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .stat   (mul_stat),
    .product(mul_prod)
  );

  kre_div #(
    .QUOT_W(QW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (div_ctl),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .stat    (div_stat),
    .quotient(div_quo),
    .overflow(div_ovf)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= PROCESS_NOISE_RESET;
      measurement_noise <= MEASUREMENT_NOISE_RESET;
      ticks_per_second  <= TICKS_PER_SECOND_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_PROCESS_NOISE:     process_noise     <= pwdata[30:0];
        REG_MEASUREMENT_NOISE: measurement_noise <= pwdata[30:0];
        REG_TICKS_PER_SECOND:  ticks_per_second  <= pwdata[29:0];
        default: begin
        end
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (paddr[3:2])
      REG_PROCESS_NOISE:     prdata = {1'b0, process_noise};
      REG_MEASUREMENT_NOISE: prdata = {1'b0, measurement_noise};
      REG_TICKS_PER_SECOND:  prdata = {2'b00, ticks_per_second};
      default:               prdata = 32'd0;
    endcase
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      estimate   <= ESTIMATE_RESET;
      covariance <= COV_RESET;
      byte_count <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            if (req.command == CMD_ADD) begin
              byte_count <= count_sum[32] ? 32'hFFFF_FFFF : count_sum[31:0];
            end else begin
              state <= S_RATE_MUL;
            end
          end
        end
        S_RATE_MUL: begin
          if (mul_stat.done) begin
            state <= S_RATE_DIV;
          end
        end
        S_RATE_DIV: begin
          if (div_stat.done) begin
            state <= S_GAIN_DIV;
          end
        end
        S_GAIN_DIV: begin
          if (div_stat.done) begin
            state <= S_EST_MUL;
          end
        end
        S_EST_MUL: begin
          if (mul_stat.done) begin
            // correction never exceeds the distance to the rate, so no wrap
            estimate <= est_up ? (estimate + corr) : (estimate - corr);
            state    <= S_COV_MUL;
          end
        end
        S_COV_MUL: begin
          if (mul_stat.done) begin
            covariance <= corr;
            byte_count <= 32'd0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per-update operands, captured as each stage finishes
  always_ff @(posedge clk) begin
    if (req_take && (req.command == CMD_UPDATE)) begin
      elapsed_q <= (req.elapsed_ticks == 24'd0) ? 24'd1 : req.elapsed_ticks;
      pm_q      <= pm_sum[32] ? 32'hFFFF_FFFF : pm_sum[31:0];
    end
    if ((state == S_RATE_MUL) && mul_stat.done) begin
      den_q <= {1'b0, pm_q} + {2'b00, measurement_noise};
    end
    if ((state == S_RATE_DIV) && div_stat.done) begin
      rate_q <= rate_val;
    end
    if ((state == S_GAIN_DIV) && div_stat.done) begin
      k_q    <= k_val;
      est_up <= up_val;
    end
  end

  // output register, frees the sequencer while the result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_DONE) && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!res_valid || res_ready)) begin
      res.average_rate <= estimate;
      res.gain         <= 31'(k_q);
    end
  end

  // an update request starts the multiplier on the next cycle
  a_update_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (req_take && (req.command == CMD_UPDATE)) |=> mul_stat.busy)
    else $error("update request did not start the multiplier");

  // the two serial units never run at the same time
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // kalman gain stays at or below one
  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EST_MUL) || (state == S_COV_MUL)) |-> (k_q <= ONE_FIX))
    else $error("gain above one");

  // a result appears only out of the final sequencer step
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_DONE))
    else $error("result valid without a finished update");

  // byte counter is cleared once the update has run
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (byte_count == 32'd0))
    else $error("byte counter not cleared after update");

endmodule

@@ test/kre_estimate_checker.sv @@
// checker for the kalman rate estimator: predicts every estimate and compares the results
`timescale 1ns / 1ps

module kre_estimate_checker import kre_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  req_t              req,
  input  logic              res_valid,
  input  logic              res_ready,
  input  res_t              res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int unsigned       estimates_due,
  output int unsigned       mismatch_count
);

  localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;
  localparam logic [79:0] ONE_FIX = 80'd1 << FRACTION_BITS;

  logic [30:0] q_noise;
  logic [30:0] r_noise;
  logic [29:0] tick_rate;
  logic [31:0] est;
  logic [31:0] covar;
  logic [31:0] byte_total;
  res_t        expected_estimates[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // measured rate, then one kalman step on estimate and covariance
  task automatic kalman_update(input logic [23:0] elapsed, output res_t out);
    logic [23:0] span;
    logic [65:0] scaled;
    logic [31:0] rate;
    logic [31:0] pm;
    logic [32:0] pm_sum;
    logic [32:0] den;
    logic [79:0] wide;
    logic [79:0] gain_w;
    logic [79:0] corr;
    logic [79:0] next;
    span   = (elapsed == '0) ? 24'd1 : elapsed;
    scaled = ({34'd0, byte_total} * {36'd0, tick_rate} * 66'd8) / {42'd0, span};
    rate   = (scaled > {34'd0, MAX32}) ? MAX32 : scaled[31:0];
    pm_sum = {1'b0, covar} + {2'b00, q_noise};
    pm     = pm_sum[32] ? MAX32 : pm_sum[31:0];
    den    = {1'b0, pm} + {2'b00, r_noise};
    wide   = {48'd0, pm};
    gain_w = (den == '0) ? '0 : (wide << FRACTION_BITS) / {47'd0, den};
    // correction truncates toward zero on either side of the estimate
    if (rate >= est) begin
      corr = ({48'd0, rate - est} * gain_w) >> FRACTION_BITS;
      next = {48'd0, est} + corr;
      est  = (next > {48'd0, MAX32}) ? MAX32 : next[31:0];
    end else begin
      corr = ({48'd0, est - rate} * gain_w) >> FRACTION_BITS;
      est  = (corr >= {48'd0, est}) ? '0 : est - corr[31:0];
    end
    next       = (wide * (ONE_FIX - gain_w)) >> FRACTION_BITS;
    covar      = (next > {48'd0, MAX32}) ? MAX32 : next[31:0];
    byte_total = '0;
    out.average_rate = est;
    out.gain         = gain_w[30:0];
  endtask

  always @(posedge clk) begin
    res_t        want;
    logic [32:0] count_next;
    if (rst) begin
      q_noise    = PROCESS_NOISE_RESET;
      r_noise    = MEASUREMENT_NOISE_RESET;
      tick_rate  = TICKS_PER_SECOND_RESET;
      est        = ESTIMATE_RESET;
      covar      = ONE_FIX[31:0];
      byte_total = '0;
      expected_estimates.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PROCESS_NOISE:     q_noise   = pwdata[30:0];
          REG_MEASUREMENT_NOISE: r_noise   = pwdata[30:0];
          REG_TICKS_PER_SECOND:  tick_rate = pwdata[29:0];
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (expected_estimates.size() == 0) begin
          report_mismatch("result with no update pending", res.average_rate, '0);
        end else begin
          want = expected_estimates.pop_front();
          if (res.average_rate !== want.average_rate)
            report_mismatch("average_rate", res.average_rate, want.average_rate);
          if (res.gain !== want.gain)
            report_mismatch("gain", {1'b0, res.gain}, {1'b0, want.gain});
        end
      end
      if (req_valid && req_ready) begin
        if (req.command == CMD_UPDATE) begin
          kalman_update(req.elapsed_ticks, want);
          expected_estimates.push_back(want);
        end else begin
          count_next = {1'b0, byte_total} + {15'd0, req.bytes};
          byte_total = count_next[32] ? MAX32 : count_next[31:0];
        end
      end
    end
    estimates_due = expected_estimates.size();
  end

endmodule

@@ test/kalman_rate_estimator_test.sv @@
// top of the kalman rate estimator testbench: stimulus, register writes and verdict
`timescale 1ns / 1ps

module kalman_rate_estimator_test;
  import kre_pkg::*;

  // a bit more than the time one update takes
  localparam int SETTLE_CYCLES = 300;
  // several times the slowest correct run
  localparam longint TIMEOUT_NS = 64'd50_000_000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 250;

  logic              clk;
  logic              rst;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_t              req = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  res_t              res;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned estimates_due;
  int unsigned mismatch_count;

  // when set, neither side inserts gaps or stalls
  bit          no_idle = 1'b0;
  int unsigned res_hold = 0;
  logic        res_taken = 1'b0;

  kalman_rate_estimator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  kre_estimate_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .estimates_due  (estimates_due),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #(TIMEOUT_NS);
    $display("kalman_rate_estimator_test failed");
    $finish;
  end

  // result side: after each accepted result, hold ready low for a random time
  always @(posedge clk) res_taken <= res_valid && res_ready;

  always @(negedge clk) begin
    int unsigned n;
    if (res_hold != 0) begin
      res_ready <= 1'b0;
      res_hold  <= res_hold - 1;
    end else if (res_taken && !no_idle) begin
      n = $urandom_range(0, 19);
      res_ready <= (n == 0);
      res_hold  <= (n == 0) ? 0 : n - 1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  function automatic req_t make_request(input logic cmd, input logic [17:0] nbytes,
                                        input logic [23:0] ticks);
    req_t r;
    r.command       = cmd;
    r.bytes         = nbytes;
    r.elapsed_ticks = ticks;
    return r;
  endfunction

  // mostly adds with an update about every fourth request; sizes lean to the edges
  function automatic req_t random_request();
    req_t r;
    r.command = ($urandom_range(0, 3) == 0) ? CMD_UPDATE : CMD_ADD;
    case ($urandom_range(0, 3))
      0:       r.bytes = $urandom_range(0, 1) ? '1 : '0;
      1:       r.bytes = 18'($urandom_range(0, 255));
      default: r.bytes = 18'($urandom_range(0, 262143));
    endcase
    case ($urandom_range(0, 4))
      0:       r.elapsed_ticks = 24'($urandom_range(0, 3));
      1:       r.elapsed_ticks = '1;
      2:       r.elapsed_ticks = 24'($urandom_range(1000, 100000));
      default: r.elapsed_ticks = 24'($urandom_range(0, 16777215));
    endcase
    return r;
  endfunction

  // called and returns at a falling edge; valid stays high into the next request
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending until every pending estimate has come back
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (estimates_due != 0);
  endtask

  // drain, then give a trailing add or update time to finish
  task automatic quiesce();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // setup cycle then access cycle; the write lands at the access edge
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] q, input logic [31:0] r,
                           input logic [31:0] tps);
    quiesce();
    write_register(REG_PROCESS_NOISE, q);
    write_register(REG_MEASUREMENT_NOISE, r);
    write_register(REG_TICKS_PER_SECOND, tps);
  endtask

  initial begin
    int unsigned tps;
    int unsigned pressure_at;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings, empty counter with a zero interval
    send_request(make_request(CMD_UPDATE, '0, '0));
    send_request(make_request(CMD_ADD, '0, 24'($urandom_range(0, 16777215))));
    send_request(make_request(CMD_ADD, '1, 24'($urandom_range(0, 16777215))));
    // one tick: largest rate that fits without saturation
    send_request(make_request(CMD_UPDATE, 18'($urandom_range(0, 262143)), 24'd1));
    send_request(make_request(CMD_ADD, 18'($urandom_range(0, 262143)), '0));
    // longest interval
    send_request(make_request(CMD_UPDATE, '1, '1));
    send_request(make_request(CMD_ADD, '1, '0));
    send_request(make_request(CMD_UPDATE, '0, '0));

    // high noise and tick rate: measured rate saturates, then falls back to zero
    configure(32'd1 << 30, 32'd1, 32'd1_000_000_000);
    send_request(make_request(CMD_ADD, '1, '1));
    send_request(make_request(CMD_UPDATE, '0, 24'd1));
    send_request(make_request(CMD_UPDATE, '1, '1));
    send_request(make_request(CMD_UPDATE, '0, '0));

    // no process noise, measurement noise of 1 << 30, one tick per second
    configure(32'd0, 32'd1 << 30, 32'd1);
    send_request(make_request(CMD_ADD, 18'd1, '0));
    send_request(make_request(CMD_UPDATE, '0, '1));
    send_request(make_request(CMD_ADD, '1, '0));
    send_request(make_request(CMD_UPDATE, '1, 24'd1));
    send_request(make_request(CMD_UPDATE, '0, '0));

    // random phases, each under its own settings
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: configure(32'd0, 32'd1, 32'd1);
        1: configure(32'd1 << 30, 32'd1 << 30, 32'd1_000_000_000);
        2: configure(32'(PROCESS_NOISE_RESET), 32'(MEASUREMENT_NOISE_RESET),
                     32'(TICKS_PER_SECOND_RESET));
        default: begin
          tps = $urandom_range(0, 1) ? $urandom_range(1, 1_000_000_000)
                                     : $urandom_range(1, 10000);
          configure($urandom_range(0, 32'd1 << 30), $urandom_range(1, 32'd1 << 30), tps);
        end
      endcase
      pressure_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // stretches with no gaps or stalls now and then
        if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        // hold off until the pipeline is empty once per phase
        if (i == pressure_at) drain();
        send_request(random_request());
      end
      no_idle = 1'b0;
    end

    quiesce();
    if (mismatch_count == 0)
      $display("kalman_rate_estimator_test passed");
    else
      $display("kalman_rate_estimator_test failed");
    $finish;
  end

endmodule
